// ===== sv/bcpe_pkg.sv =====
// shared constants, types and tables of the bezier curve point evaluator
package bcpe_pkg;

    // design sizes
    localparam int MAX_POINTS  = 8;
    localparam int COORD_BITS  = 20;
    localparam int T_FRAC_BITS = 16;
    localparam int WFRAC       = 26;

    // fixed port widths
    localparam int NP_BITS    = 4;
    localparam int PIDX_BITS  = 3;
    localparam int ADDR_BITS  = 2;
    localparam int DATA_BITS  = 32;

    // derived widths
    localparam int IDX_BITS   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int POW_BITS   = WFRAC + 1;
    localparam int U_BITS     = T_FRAC_BITS + 1;
    localparam int BINOM_BITS = MAX_POINTS;
    localparam int W_BITS     = WFRAC + 2;
    localparam int PROD_BITS  = COORD_BITS + W_BITS + 1;
    localparam int ACC_BITS   = PROD_BITS + IDX_BITS + 1;
    localparam int Q_BITS     = ACC_BITS - WFRAC;

    // queue sizes
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR   = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT   = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_PTR   = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
    localparam int RESQ_CNT   = $clog2(RESQ_DEPTH + 1);

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // register map
    localparam logic [ADDR_BITS-1:0] ADDR_NUM_POINTS = '0;
    localparam logic [NP_BITS-1:0]   NUM_POINTS_RST  = NP_BITS'(4);

    // fixed point constants
    localparam logic [POW_BITS-1:0] POW_ONE = {1'b1, {WFRAC{1'b0}}};
    localparam logic [U_BITS-1:0]   T_ONE   = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic signed [ACC_BITS-1:0] ACC_HALF =
        ACC_BITS'(64'sd1 <<< (WFRAC - 1));
    localparam logic signed [Q_BITS-1:0] Q_HI =
        Q_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [Q_BITS-1:0] Q_LO = -Q_HI - Q_BITS'(1);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // classified request as it crosses from front to back
    typedef struct packed {
        logic                    is_eval;
        logic                    load_ok;
        logic [IDX_BITS-1:0]     slot;
        point_t                  pt;
        logic [T_FRAC_BITS-1:0]  t_val;
        logic [U_BITS-1:0]       u_val;
        logic [IDX_BITS-1:0]     deg;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_UPOW,
        B_TERMS,
        B_DRAIN,
        B_DONE
    } b_state_t;

    typedef logic [MAX_POINTS-1:0][MAX_POINTS-1:0][BINOM_BITS-1:0] binom_table_t;

    // pascal triangle, row is the degree
    function automatic binom_table_t make_binom();
        binom_table_t tbl;
        tbl = '0;
        tbl[0][0] = BINOM_BITS'(1);
        for (int r = 1; r < MAX_POINTS; r++) begin
            tbl[r][0] = BINOM_BITS'(1);
            for (int j = 1; j <= r; j++) begin
                tbl[r][j] = tbl[r-1][j-1] + tbl[r-1][j];
            end
        end
        return tbl;
    endfunction

    localparam binom_table_t BINOM = make_binom();

endpackage

// ===== sv/bcpe_front.sv =====
// front end: takes requests and classifies them for the back end
module bcpe_front (
    input  logic                               push,
    input  logic                               req_type,
    input  logic [bcpe_pkg::PIDX_BITS-1:0]     point_index,
    input  logic signed [bcpe_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [bcpe_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [bcpe_pkg::COORD_BITS-1:0] point_z,
    input  logic [bcpe_pkg::T_FRAC_BITS-1:0]   t_value,
    input  logic [bcpe_pkg::NP_BITS-1:0]       num_points,
    input  logic                               cmdq_full,
    output logic                               cmdq_wr,
    output bcpe_pkg::cmd_t                     cmd
);
    import bcpe_pkg::*;

    assign cmdq_wr = push && !cmdq_full;

    always_comb
    begin
        cmd.is_eval = (req_type == REQ_EVAL);
        cmd.load_ok = (int'(point_index) < MAX_POINTS);
        cmd.slot    = IDX_BITS'(point_index);
        cmd.pt.x    = point_x;
        cmd.pt.y    = point_y;
        cmd.pt.z    = point_z;
        cmd.t_val   = t_value;
        cmd.u_val   = T_ONE - {1'b0, t_value};
        // zero count means a single point, large count is capped
        if (num_points == '0)
        begin
            cmd.deg = '0;
        end
        else if (int'(num_points) > MAX_POINTS)
        begin
            cmd.deg = IDX_BITS'(MAX_POINTS - 1);
        end
        else
        begin
            cmd.deg = IDX_BITS'(num_points - NP_BITS'(1));
        end
    end

endmodule

// ===== sv/bcpe_cmd_queue.sv =====
// short request queue between front and back
module bcpe_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  bcpe_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output bcpe_pkg::cmd_t rd_data,
    output logic           empty
);
    import bcpe_pkg::*;

    cmd_t                mem_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT-1:0] cnt_reg, cnt_next;
    logic                do_wr, do_rd;

    assign full    = (int'(cnt_reg) == CMDQ_DEPTH);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == CMDQ_DEPTH - 1) ? '0
                                                             : wr_ptr_reg + CMDQ_PTR'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == CMDQ_DEPTH - 1) ? '0
                                                             : rd_ptr_reg + CMDQ_PTR'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CMDQ_CNT'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CMDQ_CNT'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/bcpe_result_queue.sv =====
// result queue that holds finished curve points until popped
module bcpe_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  bcpe_pkg::point_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output bcpe_pkg::point_t rd_data,
    output logic             empty
);
    import bcpe_pkg::*;

    point_t              mem_reg [RESQ_DEPTH];
    logic [RESQ_PTR-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RESQ_PTR-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RESQ_CNT-1:0] cnt_reg, cnt_next;
    logic                do_wr, do_rd;

    assign full    = (int'(cnt_reg) == RESQ_DEPTH);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == RESQ_DEPTH - 1) ? '0
                                                             : wr_ptr_reg + RESQ_PTR'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == RESQ_DEPTH - 1) ? '0
                                                             : rd_ptr_reg + RESQ_PTR'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + RESQ_CNT'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - RESQ_CNT'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/bcpe_back.sv =====
// back end: point store, power tables, weight pipeline and accumulators
module bcpe_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmdq_empty,
    input  bcpe_pkg::cmd_t   cmd,
    output logic             cmdq_rd,
    input  logic             resq_full,
    output logic             resq_wr,
    output bcpe_pkg::point_t res
);
    import bcpe_pkg::*;

    b_state_t state_reg, state_next;

    // control
    logic [IDX_BITS-1:0] cnt_reg, cnt_next;
    logic                s_vld_reg, w_vld_reg, p_vld_reg;
    logic                issue, start_eval, store_we, pipe_busy;

    // payload
    point_t                  store_reg [MAX_POINTS];
    logic [IDX_BITS-1:0]     deg_reg;
    logic [T_FRAC_BITS-1:0]  t_reg;
    logic [U_BITS-1:0]       u_reg;
    logic [POW_BITS-1:0]     upow_reg [MAX_POINTS];
    logic [POW_BITS-1:0]     upow_run_reg, upow_run_next;
    logic [POW_BITS-1:0]     tpow_reg, tpow_next;
    logic [POW_BITS-1:0]     s_reg, s_next;
    logic [IDX_BITS-1:0]     s_j_reg, w_j_reg;
    logic [W_BITS-1:0]       w_reg, w_next;
    logic signed [PROD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic signed [PROD_BITS-1:0] px_next, py_next, pz_next;
    logic signed [ACC_BITS-1:0]  ax_reg, ay_reg, az_reg;

    logic [2*POW_BITS-1:0]          st_prod, st_rnd;
    logic [POW_BITS+T_FRAC_BITS:0]  tp_prod;
    logic [POW_BITS+U_BITS:0]       up_prod;
    logic [BINOM_BITS+POW_BITS-1:0] w_prod;
    logic signed [W_BITS:0]         w_s;
    point_t                         pt_rd;

    function automatic coord_t finish(input logic signed [ACC_BITS-1:0] acc);
        logic signed [ACC_BITS-1:0] rnd;
        logic signed [Q_BITS-1:0]   q;
        rnd = acc + ACC_HALF;
        q   = Q_BITS'(rnd >>> WFRAC);
        if (q > Q_HI)
        begin
            return COORD_BITS'(Q_HI);
        end
        else if (q < Q_LO)
        begin
            return COORD_BITS'(Q_LO);
        end
        return COORD_BITS'(q);
    endfunction

    assign pipe_busy = s_vld_reg || w_vld_reg || p_vld_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!cmdq_empty && cmd.is_eval)
                begin
                    state_next = (cmd.deg == '0) ? B_TERMS : B_UPOW;
                end
            end
            B_UPOW:
            begin
                if (cnt_reg == deg_reg)
                begin
                    state_next = B_TERMS;
                end
            end
            B_TERMS:
            begin
                if (cnt_reg == deg_reg)
                begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!resq_full)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        cmdq_rd    = 1'b0;
        start_eval = 1'b0;
        store_we   = 1'b0;
        issue      = 1'b0;
        resq_wr    = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                cmdq_rd    = !cmdq_empty;
                start_eval = !cmdq_empty && cmd.is_eval;
                store_we   = !cmdq_empty && !cmd.is_eval && cmd.load_ok;
            end
            B_TERMS:
            begin
                issue = 1'b1;
            end
            B_DONE:
            begin
                resq_wr = !resq_full;
            end
            default:
            begin
                cmdq_rd = 1'b0;
            end
        endcase
    end

    // counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (start_eval)
        begin
            cnt_next = (cmd.deg == '0) ? '0 : IDX_BITS'(1);
        end
        else if (state_reg == B_UPOW || state_reg == B_TERMS)
        begin
            cnt_next = (cnt_reg == deg_reg) ? '0 : cnt_reg + IDX_BITS'(1);
        end
    end

    // power recurrences and the weight pipeline
    always_comb
    begin
        up_prod       = (POW_BITS+U_BITS+1)'(upow_run_reg) * (POW_BITS+U_BITS+1)'(u_reg)
                        + (POW_BITS+U_BITS+1)'(1 << (T_FRAC_BITS - 1));
        upow_run_next = POW_BITS'(up_prod >> T_FRAC_BITS);

        tp_prod   = (POW_BITS+T_FRAC_BITS+1)'(tpow_reg) * (POW_BITS+T_FRAC_BITS+1)'(t_reg)
                    + (POW_BITS+T_FRAC_BITS+1)'(1 << (T_FRAC_BITS - 1));
        tpow_next = POW_BITS'(tp_prod >> T_FRAC_BITS);

        st_prod = (2*POW_BITS)'(tpow_reg) * (2*POW_BITS)'(upow_reg[deg_reg - cnt_reg]);
        st_rnd  = st_prod + (2*POW_BITS)'(1 << (WFRAC - 1));
        s_next  = POW_BITS'(st_rnd >> WFRAC);

        w_prod = (BINOM_BITS+POW_BITS)'(BINOM[deg_reg][s_j_reg])
                 * (BINOM_BITS+POW_BITS)'(s_reg);
        w_next = W_BITS'(w_prod);

        pt_rd   = store_reg[w_j_reg];
        w_s     = {1'b0, w_reg};
        px_next = PROD_BITS'(pt_rd.x) * PROD_BITS'(w_s);
        py_next = PROD_BITS'(pt_rd.y) * PROD_BITS'(w_s);
        pz_next = PROD_BITS'(pt_rd.z) * PROD_BITS'(w_s);

        res.x = finish(ax_reg);
        res.y = finish(ay_reg);
        res.z = finish(az_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            s_vld_reg <= 1'b0;
            w_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            s_vld_reg <= issue;
            w_vld_reg <= s_vld_reg;
            p_vld_reg <= w_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[cmd.slot] <= cmd.pt;
        end
        if (start_eval)
        begin
            deg_reg      <= cmd.deg;
            t_reg        <= cmd.t_val;
            u_reg        <= cmd.u_val;
            upow_reg[0]  <= POW_ONE;
            upow_run_reg <= POW_ONE;
            tpow_reg     <= POW_ONE;
        end
        if (state_reg == B_UPOW)
        begin
            upow_reg[cnt_reg] <= upow_run_next;
            upow_run_reg      <= upow_run_next;
        end
        if (issue)
        begin
            tpow_reg <= tpow_next;
        end
        s_reg   <= s_next;
        s_j_reg <= cnt_reg;
        w_reg   <= w_next;
        w_j_reg <= s_j_reg;
        px_reg  <= px_next;
        py_reg  <= py_next;
        pz_reg  <= pz_next;
        if (start_eval)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
            az_reg <= '0;
        end
        else if (p_vld_reg)
        begin
            ax_reg <= ax_reg + ACC_BITS'(px_reg);
            ay_reg <= ay_reg + ACC_BITS'(py_reg);
            az_reg <= az_reg + ACC_BITS'(pz_reg);
        end
    end

endmodule

// ===== sv/bezier_curve_point_evaluator.sv =====
// top level of the bezier curve point evaluator
//
// channel   direction  handshake                       payload
// request   in         push / full                     req_type, point_index, point_x/y/z,
//                                                      t_value
// result    out        pop / empty                     curve_x, curve_y, curve_z
// config    in         psel, penable, pwrite, pready   paddr, pwdata, prdata (num_points)
//
// a load request is stored from the idle state of the back end and gives no result
// an evaluate request steps the back end through its states (d = points in use minus one):
//   a start from idle, the (1-t) power chain up to the power d, the d + 1 terms issued
//   one per cycle, a drain of the four stage weight and multiply-accumulate pipeline, and
//   a hand-off of the result
// requests are taken while the two entry request queue has room, so the front
//   keeps accepting while the back end works or a result waits to be popped
// the back end holds a finished result until the two entry result queue has room
// reset clears num_points to four; the point store holds nothing until loaded
//
// result: sum over j of P_j * C(d,j) * t^j * (1-t)^(d-j), rounded and saturated
module bezier_curve_point_evaluator (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // request side
    input  logic                                   push,
    output logic                                   full,
    input  logic                                   req_type,
    input  logic [bcpe_pkg::PIDX_BITS-1:0]         point_index,
    input  logic signed [bcpe_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [bcpe_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [bcpe_pkg::COORD_BITS-1:0] point_z,
    input  logic [bcpe_pkg::T_FRAC_BITS-1:0]       t_value,

    // result side
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [bcpe_pkg::COORD_BITS-1:0] curve_x,
    output logic signed [bcpe_pkg::COORD_BITS-1:0] curve_y,
    output logic signed [bcpe_pkg::COORD_BITS-1:0] curve_z,

    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [bcpe_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [bcpe_pkg::DATA_BITS-1:0]         pwdata,
    output logic [bcpe_pkg::DATA_BITS-1:0]         prdata,
    output logic                                   pready
);
    import bcpe_pkg::*;

    logic [NP_BITS-1:0] num_points_reg, num_points_next;
    logic               cfg_wr;

    cmd_t   front_cmd, back_cmd;
    logic   cmdq_wr, cmdq_full, cmdq_rd, cmdq_empty;
    logic   resq_wr, resq_full;
    point_t back_res, out_res;

    // config register: only one, so writes need no decode; reads check the address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == ADDR_NUM_POINTS) ? DATA_BITS'(num_points_reg) : '0;

    always_comb
    begin
        num_points_next = num_points_reg;
        if (cfg_wr)
        begin
            num_points_next = pwdata[NP_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= NUM_POINTS_RST;
        end
        else
        begin
            num_points_reg <= num_points_next;
        end
    end

    // front: accept and classify each request
    bcpe_front u_front (
        .push        (push),
        .req_type    (req_type),
        .point_index (point_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .t_value     (t_value),
        .num_points  (num_points_reg),
        .cmdq_full   (cmdq_full),
        .cmdq_wr     (cmdq_wr),
        .cmd         (front_cmd)
    );

    assign full = cmdq_full;

    // decouples the front from the back
    bcpe_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmdq_wr),
        .wr_data (front_cmd),
        .full    (cmdq_full),
        .rd_en   (cmdq_rd),
        .rd_data (back_cmd),
        .empty   (cmdq_empty)
    );

    // back: store loads, evaluate the curve in program order
    bcpe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmdq_empty (cmdq_empty),
        .cmd        (back_cmd),
        .cmdq_rd    (cmdq_rd),
        .resq_full  (resq_full),
        .resq_wr    (resq_wr),
        .res        (back_res)
    );

    // finished points wait here for the consumer
    bcpe_result_queue u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (resq_wr),
        .wr_data (back_res),
        .full    (resq_full),
        .rd_en   (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign curve_x = out_res.x;
    assign curve_y = out_res.y;
    assign curve_z = out_res.z;

endmodule
